// ----- rtl/sbr_pkg.sv -----
// ----------------------------------------------------------------------------
// sbr_pkg
// Shared widths, types and constants for the signed window bucket recoder.
// ----------------------------------------------------------------------------
package sbr_pkg;

   localparam int WindowWidth  = 14;
   localparam int WindowCount  = 19;
   localparam int ScalarWidth  = 255;
   localparam int ChainWidth   = WindowWidth * WindowCount;
   localparam int NumWidth     = 5;
   localparam int CountWidth   = 5;
   localparam int TagWidth     = 32;
   localparam int LimbWidth    = 64;
   localparam int TopLimbWidth = 63;
   localparam int ReqDataWidth = 288;
   localparam int RspDataWidth = 56;
   localparam int RspUserWidth = 2;
   localparam int TagShift     = 3;

   localparam logic [NumWidth-1:0]   LastWindow = NumWidth'(WindowCount - 1);
   localparam logic [CountWidth-1:0] FullCount  = CountWidth'(WindowCount);

   typedef logic [WindowWidth-1:0] window_type;
   typedef logic [NumWidth-1:0]    num_type;
   typedef logic [TagWidth-1:0]    tag_type;

   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctl_type;

   typedef struct packed {
      logic    advance;
      logic    last;
      num_type number;
   } emit_ctl_type;

   typedef struct packed {
      num_type    window_number;
      window_type bucket_index;
      logic       no_bucket;
      logic       subtract;
      tag_type    point_tag;
      logic       last;
   } result_type;

endpackage

// ----- rtl/sbr_cell.sv -----
// ----------------------------------------------------------------------------
// sbr_cell
// One window slot of the chain: load in parallel or take the neighbor's value.
// ----------------------------------------------------------------------------
module sbr_cell #(
   parameter int WIDTH = sbr_pkg::WindowWidth
) (
   input  logic                 clock,
   input  sbr_pkg::cell_ctl_type ctl,
   input  logic [WIDTH-1:0]     load_window,
   input  logic [WIDTH-1:0]     next_window,
   output logic [WIDTH-1:0]     window
);

   logic [WIDTH-1:0] window_ff;
   logic [WIDTH-1:0] window_in;

   always_comb begin
      window_in = window_ff;
      if (ctl.load) begin
         window_in = load_window;
      end else if (ctl.shift) begin
         window_in = next_window;
      end
   end

   always_ff @(posedge clock) begin
      window_ff <= window_in;
   end

   assign window = window_ff;

endmodule

// ----- rtl/sbr_emit.sv -----
// ----------------------------------------------------------------------------
// sbr_emit
// Head of the chain: signed-digit recode with running carry, output register.
// ----------------------------------------------------------------------------
module sbr_emit (
   input  logic                  clock,
   input  logic                  reset,
   input  sbr_pkg::emit_ctl_type ctl,
   input  sbr_pkg::window_type   window,
   input  sbr_pkg::tag_type      tag,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output sbr_pkg::result_type   result
);

   localparam int SumWidth = sbr_pkg::WindowWidth + 1;
   localparam logic [SumWidth-1:0] FullValue = SumWidth'(1) << sbr_pkg::WindowWidth;

   logic                 valid_ff;
   logic                 valid_in;
   logic                 carry_ff;
   logic                 carry_in;
   sbr_pkg::result_type  result_ff;
   sbr_pkg::result_type  result_in;

   logic [SumWidth-1:0]  sum;
   logic                 high;
   logic [SumWidth-1:0]  digit;
   logic                 zero_digit;
   sbr_pkg::window_type  offset;
   sbr_pkg::window_type  bucket;

   always_comb begin
      sum        = {1'b0, window} + SumWidth'(carry_ff);
      high       = sum[SumWidth-1] | sum[SumWidth-2];
      digit      = high ? (FullValue - sum) : sum;
      zero_digit = (digit == '0);
      offset     = ctl.last ? {tag[sbr_pkg::WindowWidth-sbr_pkg::TagShift-1:0],
                               sbr_pkg::TagShift'(0)} : '0;
      bucket     = zero_digit ? '0 :
                   (digit[sbr_pkg::WindowWidth-1:0] - sbr_pkg::WindowWidth'(1) + offset);

      result_in               = result_ff;
      result_in.window_number = ctl.number;
      result_in.bucket_index  = bucket;
      result_in.no_bucket     = zero_digit;
      result_in.subtract      = high;
      result_in.point_tag     = tag;
      result_in.last          = ctl.last;
      if (!ctl.advance) begin
         result_in = result_ff;
      end

      carry_in = carry_ff;
      if (ctl.advance) begin
         carry_in = high & ~ctl.last;
      end

      valid_in = ctl.advance | (valid_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         carry_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         carry_ff <= carry_in;
      end
      result_ff <= result_in;
   end

   assign rsp_valid = valid_ff;
   assign result    = result_ff;

endmodule

// ----- rtl/signed_window_bucket_recoder.sv -----
// ----------------------------------------------------------------------------
// signed_window_bucket_recoder
// Cuts a 255-bit scalar into 19 signed 14-bit digits, one bucket op each.
// ----------------------------------------------------------------------------
//   channel  direction  transfer contents
//   req_*    in         limbs 0..3 and point index, one scalar per transfer
//   rsp_*    out        one bucket operation per window, 19 per scalar
//
// A scalar loads the 19-cell window chain in parallel; the chain then shifts
// one window per cycle into the recode stage while rsp_tready does not stall it.
// The next scalar loads in the cycle the final window leaves the chain.
// A stalled rsp_tready holds the output register and freezes the chain.
// Synchronous reset clears the chain count, carry and output valid.
// ----------------------------------------------------------------------------
module signed_window_bucket_recoder (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // limb0[63:0], limb1[127:64], limb2[191:128], limb3[254:192],
   // point_index[286:255], zero[287]
   input  logic [287:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // window_number[4:0], bucket_index[18:5], point_tag[50:19], zero[55:51]
   output logic [55:0]  rsp_tdata,
   // no_bucket[0], subtract[1]
   output logic [1:0]   rsp_tuser,
   output logic         rsp_tlast
);

   localparam int Ww = sbr_pkg::WindowWidth;
   localparam int Wc = sbr_pkg::WindowCount;
   localparam int Lw = sbr_pkg::LimbWidth;

   logic [sbr_pkg::CountWidth-1:0] count_ff;
   logic [sbr_pkg::CountWidth-1:0] count_in;
   sbr_pkg::num_type               number_ff;
   sbr_pkg::num_type               number_in;
   sbr_pkg::tag_type               tag_ff;
   sbr_pkg::tag_type               tag_in;

   logic                           advance;
   logic                           accept;
   sbr_pkg::cell_ctl_type          cell_ctl;
   sbr_pkg::emit_ctl_type          emit_ctl;
   sbr_pkg::result_type            result;
   logic [sbr_pkg::ChainWidth-1:0] scalar;
   sbr_pkg::window_type            chain [Wc+1];

   assign advance    = (count_ff != '0) & (~rsp_tvalid | rsp_tready);
   assign req_tready = (count_ff == '0) |
                       ((count_ff == sbr_pkg::CountWidth'(1)) & advance);
   assign accept     = req_tvalid & req_tready;

   assign scalar = {(sbr_pkg::ChainWidth - sbr_pkg::ScalarWidth)'(0),
                    req_tdata[3*Lw +: sbr_pkg::TopLimbWidth],
                    req_tdata[2*Lw +: Lw],
                    req_tdata[Lw +: Lw],
                    req_tdata[0 +: Lw]};

   always_comb begin
      count_in  = count_ff;
      number_in = number_ff;
      tag_in    = tag_ff;
      if (accept) begin
         count_in  = sbr_pkg::FullCount;
         number_in = '0;
         tag_in    = req_tdata[sbr_pkg::ScalarWidth +: sbr_pkg::TagWidth];
      end else if (advance) begin
         count_in  = count_ff - sbr_pkg::CountWidth'(1);
         number_in = number_ff + sbr_pkg::NumWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      number_ff <= number_in;
      tag_ff    <= tag_in;
   end

   assign cell_ctl.load  = accept;
   assign cell_ctl.shift = advance;

   assign chain[Wc] = '0;

   for (genvar i = 0; i < Wc; i++) begin : g_cell
      sbr_cell #(
         .WIDTH(Ww)
      ) u_cell (
         .clock      (clock),
         .ctl        (cell_ctl),
         .load_window(scalar[i*Ww +: Ww]),
         .next_window(chain[i+1]),
         .window     (chain[i])
      );
   end

   assign emit_ctl.advance = advance;
   assign emit_ctl.last    = (number_ff == sbr_pkg::LastWindow);
   assign emit_ctl.number  = number_ff;

   sbr_emit u_emit (
      .clock    (clock),
      .reset    (reset),
      .ctl      (emit_ctl),
      .window   (chain[0]),
      .tag      (tag_ff),
      .rsp_ready(rsp_tready),
      .rsp_valid(rsp_tvalid),
      .result   (result)
   );

   assign rsp_tdata = {5'd0, result.point_tag, result.bucket_index, result.window_number};
   assign rsp_tuser = {result.subtract, result.no_bucket};
   assign rsp_tlast = result.last;

`ifndef NO_ASSERTIONS
   a_last_window: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> result.window_number == sbr_pkg::LastWindow)
      else $error("final window transfer carries the wrong window number");

   a_no_bucket_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && result.no_bucket |-> result.bucket_index == '0)
      else $error("bucket index nonzero on a zero digit");

   a_load_full: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> count_ff == sbr_pkg::FullCount)
      else $error("chain count not full after a scalar transfer");

   a_load_when_done: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |-> count_ff <= sbr_pkg::CountWidth'(1))
      else $error("scalar taken while the chain still holds windows");
`endif

endmodule
